@@ hw/rtl/ffaa_pkg.sv @@
// Shared types and codes of the first-fit arena allocator.
// Used by ffaa_ctrl, ffaa_datapath and the top level; depends on nothing.
package ffaa_pkg;

	localparam int ADDR_W = 18;
	localparam int WORD_W = 24;
	localparam int LIVE_W = 13;
	localparam logic [17:0] HDR = 18'd12;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] MOP_IDLE = 2'd0;
	localparam logic [1:0] MOP_RDW  = 2'd1;
	localparam logic [1:0] MOP_WRW  = 2'd2;
	localparam logic [1:0] MOP_CLR  = 2'd3;

	localparam logic [3:0] ASEL_ZERO   = 4'd0;
	localparam logic [3:0] ASEL_FOUR   = 4'd1;
	localparam logic [3:0] ASEL_EIGHT  = 4'd2;
	localparam logic [3:0] ASEL_HEAD   = 4'd3;
	localparam logic [3:0] ASEL_P1     = 4'd4;
	localparam logic [3:0] ASEL_P1_4   = 4'd5;
	localparam logic [3:0] ASEL_P1_8   = 4'd6;
	localparam logic [3:0] ASEL_P2     = 4'd7;
	localparam logic [3:0] ASEL_P2_4   = 4'd8;
	localparam logic [3:0] ASEL_END    = 4'd9;
	localparam logic [3:0] ASEL_END_4  = 4'd10;
	localparam logic [3:0] ASEL_END_8  = 4'd11;
	localparam logic [3:0] ASEL_TAIL   = 4'd12;
	localparam logic [3:0] ASEL_TAIL_8 = 4'd13;
	localparam logic [3:0] ASEL_TGT    = 4'd14;
	localparam logic [3:0] ASEL_PRV    = 4'd15;

	localparam logic [2:0] DSEL_ZERO      = 3'd0;
	localparam logic [2:0] DSEL_HEAD_LIVE = 3'd1;
	localparam logic [2:0] DSEL_REQ       = 3'd2;
	localparam logic [2:0] DSEL_P1        = 3'd3;
	localparam logic [2:0] DSEL_P2        = 3'd4;
	localparam logic [2:0] DSEL_END       = 3'd5;
	localparam logic [2:0] DSEL_TAIL      = 3'd6;
	localparam logic [2:0] DSEL_PRV       = 3'd7;

	localparam logic [4:0] ACT_NONE        = 5'd0;
	localparam logic [4:0] ACT_LOAD        = 5'd1;
	localparam logic [4:0] ACT_HEAD_ZERO   = 5'd2;
	localparam logic [4:0] ACT_P1_HEAD     = 5'd3;
	localparam logic [4:0] ACT_S1_W        = 5'd4;
	localparam logic [4:0] ACT_END         = 5'd5;
	localparam logic [4:0] ACT_GRANT_GAP   = 5'd6;
	localparam logic [4:0] ACT_ADV         = 5'd7;
	localparam logic [4:0] ACT_TAIL_END    = 5'd8;
	localparam logic [4:0] ACT_GRANT_TAIL  = 5'd9;
	localparam logic [4:0] ACT_CUR_HEAD    = 5'd10;
	localparam logic [4:0] ACT_CUR_NEXT    = 5'd11;
	localparam logic [4:0] ACT_NXT         = 5'd12;
	localparam logic [4:0] ACT_PRV         = 5'd13;
	localparam logic [4:0] ACT_UNLINK_HEAD = 5'd14;
	localparam logic [4:0] ACT_UNLINK_TAIL = 5'd15;
	localparam logic [4:0] ACT_FREE_DONE   = 5'd16;
	localparam logic [4:0] ACT_RDB_DONE    = 5'd17;

	typedef struct packed {
		logic [1:0] mop;
		logic [3:0] asel;
		logic [2:0] dsel;
		logic       full_clr;
		logic [4:0] act;
		logic       push;
	} ctl_cmd_t;

	typedef struct packed {
		logic       mem_done;
		logic [1:0] op;
		logic       need_gt_lim;
		logic       front_ok;
		logic       w_zero;
		logic       k_lt_live;
		logic       gap_ok;
		logic       tail_ok;
		logic       cur_match;
		logic       cur_is_head;
		logic       cur_is_tail;
		logic       tgt_lt_lim;
		logic       out_busy;
	} ctl_stat_t;

endpackage

@@ hw/rtl/ffaa_ctrl.sv @@
// Sequencing state machine of the first-fit arena allocator.
// Drives ffaa_datapath through ffaa_pkg::ctl_cmd_t and reads ffaa_pkg::ctl_stat_t.
module ffaa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                arena_size_we,
	input  ffaa_pkg::ctl_stat_t st,
	output ffaa_pkg::ctl_cmd_t  cmd,
	output logic                in_stall
);

	localparam logic [5:0] S_CLR    = 6'd0;
	localparam logic [5:0] S_IDLE   = 6'd1;
	localparam logic [5:0] S_DISP   = 6'd2;
	localparam logic [5:0] S_RDB    = 6'd3;
	localparam logic [5:0] S_A_CHK  = 6'd4;
	localparam logic [5:0] S_A_F0   = 6'd5;
	localparam logic [5:0] S_A_F1   = 6'd6;
	localparam logic [5:0] S_A_F2   = 6'd7;
	localparam logic [5:0] S_A_RH   = 6'd8;
	localparam logic [5:0] S_A_RH2  = 6'd9;
	localparam logic [5:0] S_A_RS1  = 6'd10;
	localparam logic [5:0] S_A_END  = 6'd11;
	localparam logic [5:0] S_A_GAP  = 6'd12;
	localparam logic [5:0] S_A_G0   = 6'd13;
	localparam logic [5:0] S_A_G1   = 6'd14;
	localparam logic [5:0] S_A_G2   = 6'd15;
	localparam logic [5:0] S_A_G3   = 6'd16;
	localparam logic [5:0] S_A_G4   = 6'd17;
	localparam logic [5:0] S_A_RN   = 6'd18;
	localparam logic [5:0] S_A_RN2  = 6'd19;
	localparam logic [5:0] S_T_RS   = 6'd20;
	localparam logic [5:0] S_T_CHK  = 6'd21;
	localparam logic [5:0] S_T_W0   = 6'd22;
	localparam logic [5:0] S_T_W1   = 6'd23;
	localparam logic [5:0] S_T_W2   = 6'd24;
	localparam logic [5:0] S_T_W3   = 6'd25;
	localparam logic [5:0] S_F_INIT = 6'd26;
	localparam logic [5:0] S_F_CHK  = 6'd27;
	localparam logic [5:0] S_F_STEP = 6'd28;
	localparam logic [5:0] S_F_RN   = 6'd29;
	localparam logic [5:0] S_F_RP   = 6'd30;
	localparam logic [5:0] S_F_RS   = 6'd31;
	localparam logic [5:0] S_F_END  = 6'd32;
	localparam logic [5:0] S_F_UH   = 6'd33;
	localparam logic [5:0] S_F_UT   = 6'd34;
	localparam logic [5:0] S_F_CLR  = 6'd35;
	localparam logic [5:0] S_DONE   = 6'd36;

	logic [5:0] state_q;
	logic [5:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE) | arena_size_we;

	always_comb begin
		state_d      = state_q;
		cmd.mop      = ffaa_pkg::MOP_IDLE;
		cmd.asel     = ffaa_pkg::ASEL_ZERO;
		cmd.dsel     = ffaa_pkg::DSEL_ZERO;
		cmd.full_clr = 1'b0;
		cmd.act      = ffaa_pkg::ACT_NONE;
		cmd.push     = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.mop      = ffaa_pkg::MOP_CLR;
				cmd.full_clr = 1'b1;
				if (st.mem_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (arena_size_we) begin
					state_d = S_CLR;
				end else if (in_valid) begin
					cmd.act = ffaa_pkg::ACT_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (st.op)
					ffaa_pkg::OP_ALLOC: state_d = S_A_CHK;
					ffaa_pkg::OP_FREE:  state_d = S_F_INIT;
					ffaa_pkg::OP_READ:  state_d = S_RDB;
					default:            state_d = S_DONE;
				endcase
			end
			S_RDB: begin
				if (!st.tgt_lt_lim) begin
					state_d = S_DONE;
				end else begin
					cmd.mop  = ffaa_pkg::MOP_RDW;
					cmd.asel = ffaa_pkg::ASEL_TGT;
					if (st.mem_done) begin
						cmd.act = ffaa_pkg::ACT_RDB_DONE;
						state_d = S_DONE;
					end
				end
			end
			S_A_CHK: begin
				if (st.need_gt_lim) state_d = S_DONE;
				else if (st.front_ok) state_d = S_A_F0;
				else state_d = S_A_RH;
			end
			S_A_F0: begin
				cmd.mop  = ffaa_pkg::MOP_WRW;
				cmd.asel = ffaa_pkg::ASEL_ZERO;
				cmd.dsel = ffaa_pkg::DSEL_HEAD_LIVE;
				if (st.mem_done) state_d = S_A_F1;
			end
			S_A_F1: begin
				cmd.mop  = ffaa_pkg::MOP_WRW;
				cmd.asel = ffaa_pkg::ASEL_FOUR;
				cmd.dsel = ffaa_pkg::DSEL_ZERO;
				if (st.mem_done) state_d = S_A_F2;
			end
			S_A_F2: begin
				cmd.mop  = ffaa_pkg::MOP_WRW;
				cmd.asel = ffaa_pkg::ASEL_EIGHT;
				cmd.dsel = ffaa_pkg::DSEL_REQ;
				if (st.mem_done) begin
					cmd.act = ffaa_pkg::ACT_HEAD_ZERO;
					state_d = S_DONE;
				end
			end
			S_A_RH: begin
				cmd.mop  = ffaa_pkg::MOP_RDW;
				cmd.asel = ffaa_pkg::ASEL_HEAD;
				if (st.mem_done) state_d = S_A_RH2;
			end
			S_A_RH2: begin
				if (st.w_zero) begin
					state_d = S_T_RS;
				end else begin
					cmd.act = ffaa_pkg::ACT_P1_HEAD;
					state_d = S_A_RS1;
				end
			end
			S_A_RS1: begin
				cmd.mop  = ffaa_pkg::MOP_RDW;
				cmd.asel = ffaa_pkg::ASEL_P1_8;
				if (st.mem_done) begin
					cmd.act = ffaa_pkg::ACT_S1_W;
					state_d = S_A_END;
				end
			end
			S_A_END: begin
				if (!st.k_lt_live) begin
					state_d = S_T_RS;
				end else begin
					cmd.act = ffaa_pkg::ACT_END;
					state_d = S_A_GAP;
				end
			end
			S_A_GAP: begin
				state_d = st.gap_ok ? S_A_G0 : S_A_RN;
			end
			S_A_G0: begin
				cmd.mop  = ffaa_pkg::MOP_WRW;
				cmd.asel = ffaa_pkg::ASEL_END;
				cmd.dsel = ffaa_pkg::DSEL_P2;
				if (st.mem_done) state_d = S_A_G1;
			end
			S_A_G1: begin
				cmd.mop  = ffaa_pkg::MOP_WRW;
				cmd.asel = ffaa_pkg::ASEL_END_4;
				cmd.dsel = ffaa_pkg::DSEL_P1;
				if (st.mem_done) state_d = S_A_G2;
			end
			S_A_G2: begin
				cmd.mop  = ffaa_pkg::MOP_WRW;
				cmd.asel = ffaa_pkg::ASEL_END_8;
				cmd.dsel = ffaa_pkg::DSEL_REQ;
				if (st.mem_done) state_d = S_A_G3;
			end
			S_A_G3: begin
				cmd.mop  = ffaa_pkg::MOP_WRW;
				cmd.asel = ffaa_pkg::ASEL_P1;
				cmd.dsel = ffaa_pkg::DSEL_END;
				if (st.mem_done) state_d = S_A_G4;
			end
			S_A_G4: begin
				cmd.mop  = ffaa_pkg::MOP_WRW;
				cmd.asel = ffaa_pkg::ASEL_P2_4;
				cmd.dsel = ffaa_pkg::DSEL_END;
				if (st.mem_done) begin
					cmd.act = ffaa_pkg::ACT_GRANT_GAP;
					state_d = S_DONE;
				end
			end
			S_A_RN: begin
				cmd.mop  = ffaa_pkg::MOP_RDW;
				cmd.asel = ffaa_pkg::ASEL_P2;
				if (st.mem_done) state_d = S_A_RN2;
			end
			S_A_RN2: begin
				if (st.w_zero) begin
					state_d = S_T_RS;
				end else begin
					cmd.act = ffaa_pkg::ACT_ADV;
					state_d = S_A_RS1;
				end
			end
			S_T_RS: begin
				cmd.mop  = ffaa_pkg::MOP_RDW;
				cmd.asel = ffaa_pkg::ASEL_TAIL_8;
				if (st.mem_done) begin
					cmd.act = ffaa_pkg::ACT_TAIL_END;
					state_d = S_T_CHK;
				end
			end
			S_T_CHK: begin
				state_d = st.tail_ok ? S_T_W0 : S_DONE;
			end
			S_T_W0: begin
				cmd.mop  = ffaa_pkg::MOP_WRW;
				cmd.asel = ffaa_pkg::ASEL_END;
				cmd.dsel = ffaa_pkg::DSEL_ZERO;
				if (st.mem_done) state_d = S_T_W1;
			end
			S_T_W1: begin
				cmd.mop  = ffaa_pkg::MOP_WRW;
				cmd.asel = ffaa_pkg::ASEL_END_4;
				cmd.dsel = ffaa_pkg::DSEL_TAIL;
				if (st.mem_done) state_d = S_T_W2;
			end
			S_T_W2: begin
				cmd.mop  = ffaa_pkg::MOP_WRW;
				cmd.asel = ffaa_pkg::ASEL_END_8;
				cmd.dsel = ffaa_pkg::DSEL_REQ;
				if (st.mem_done) state_d = S_T_W3;
			end
			S_T_W3: begin
				cmd.mop  = ffaa_pkg::MOP_WRW;
				cmd.asel = ffaa_pkg::ASEL_TAIL;
				cmd.dsel = ffaa_pkg::DSEL_END;
				if (st.mem_done) begin
					cmd.act = ffaa_pkg::ACT_GRANT_TAIL;
					state_d = S_DONE;
				end
			end
			S_F_INIT: begin
				cmd.act = ffaa_pkg::ACT_CUR_HEAD;
				state_d = S_F_CHK;
			end
			S_F_CHK: begin
				if (!st.k_lt_live) state_d = S_DONE;
				else if (st.cur_match) state_d = S_F_RN;
				else state_d = S_F_STEP;
			end
			S_F_STEP: begin
				cmd.mop  = ffaa_pkg::MOP_RDW;
				cmd.asel = ffaa_pkg::ASEL_P1;
				if (st.mem_done) begin
					cmd.act = ffaa_pkg::ACT_CUR_NEXT;
					state_d = S_F_CHK;
				end
			end
			S_F_RN: begin
				cmd.mop  = ffaa_pkg::MOP_RDW;
				cmd.asel = ffaa_pkg::ASEL_P1;
				if (st.mem_done) begin
					cmd.act = ffaa_pkg::ACT_NXT;
					state_d = S_F_RP;
				end
			end
			S_F_RP: begin
				cmd.mop  = ffaa_pkg::MOP_RDW;
				cmd.asel = ffaa_pkg::ASEL_P1_4;
				if (st.mem_done) begin
					cmd.act = ffaa_pkg::ACT_PRV;
					state_d = S_F_RS;
				end
			end
			S_F_RS: begin
				cmd.mop  = ffaa_pkg::MOP_RDW;
				cmd.asel = ffaa_pkg::ASEL_P1_8;
				if (st.mem_done) begin
					cmd.act = ffaa_pkg::ACT_S1_W;
					state_d = S_F_END;
				end
			end
			S_F_END: begin
				cmd.act = ffaa_pkg::ACT_END;
				state_d = S_F_UH;
			end
			S_F_UH: begin
				if (st.cur_is_head) begin
					cmd.act = ffaa_pkg::ACT_UNLINK_HEAD;
					state_d = S_F_UT;
				end else begin
					cmd.mop  = ffaa_pkg::MOP_WRW;
					cmd.asel = ffaa_pkg::ASEL_PRV;
					cmd.dsel = ffaa_pkg::DSEL_P2;
					if (st.mem_done) state_d = S_F_UT;
				end
			end
			S_F_UT: begin
				if (st.cur_is_tail) begin
					cmd.act = ffaa_pkg::ACT_UNLINK_TAIL;
					state_d = S_F_CLR;
				end else begin
					cmd.mop  = ffaa_pkg::MOP_WRW;
					cmd.asel = ffaa_pkg::ASEL_P2_4;
					cmd.dsel = ffaa_pkg::DSEL_PRV;
					if (st.mem_done) state_d = S_F_CLR;
				end
			end
			S_F_CLR: begin
				cmd.mop  = ffaa_pkg::MOP_CLR;
				cmd.asel = ffaa_pkg::ASEL_P1;
				if (st.mem_done) begin
					cmd.act = ffaa_pkg::ACT_FREE_DONE;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!st.out_busy) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ hw/rtl/ffaa_datapath.sv @@
// Datapath of the first-fit arena allocator: arena memory, word access unit,
// list registers and the output register. Uses types and codes from ffaa_pkg.
module ffaa_datapath #(
	parameter int ARENA_BYTES = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                arena_size_we,
	input  logic [16:0]         arena_size,
	input  logic [1:0]          op,
	input  logic [16:0]         request_size,
	input  logic [15:0]         target_offset,
	input  logic                out_stall,
	input  ffaa_pkg::ctl_cmd_t  cmd,
	output ffaa_pkg::ctl_stat_t st,
	output logic                out_valid,
	output logic [15:0]         granted_offset,
	output logic [7:0]          read_byte
);

	localparam int CAP = (ARENA_BYTES < 65536) ? ARENA_BYTES : 65536;
	localparam int AW  = $clog2(CAP);
	localparam logic [17:0] CAP18 = 18'(CAP);

	logic [7:0] arena_q [0:CAP-1];

	logic [16:0] lim_q;
	logic [15:0] head_q;
	logic [15:0] tail_q;
	logic [ffaa_pkg::LIVE_W-1:0] live_q;
	logic [ffaa_pkg::LIVE_W-1:0] k_q;
	logic [1:0]  op_q;
	logic [16:0] req_q;
	logic [15:0] tgt_q;
	logic [17:0] p1_q;
	logic [17:0] p2_q;
	logic [17:0] s1_q;
	logic [17:0] end_q;
	logic [17:0] prv_q;
	logic [ffaa_pkg::WORD_W-1:0] w_q;
	logic [15:0] grant_q;
	logic [7:0]  byte_q;

	// Memory access unit.
	logic        mbusy_q;
	logic        mdone_q;
	logic [1:0]  mop_q;
	logic [1:0]  mcnt_q;
	logic [17:0] maddr_q;
	logic [17:0] mend_q;
	logic [ffaa_pkg::WORD_W-1:0] mdat_q;
	logic [7:0]  rdata_s1;
	logic        ok_s1;

	logic        go;
	logic [17:0] addr_mux;
	logic [ffaa_pkg::WORD_W-1:0] data_mux;
	logic        mem_we;
	logic [7:0]  mem_wd;
	logic        maddr_ok;
	logic        clr_more;
	logic [17:0] need;
	logic [17:0] lim18;
	logic [7:0]  rbyte;

	assign need     = {1'b0, req_q} + ffaa_pkg::HDR;
	assign lim18    = {1'b0, lim_q};
	assign maddr_ok = maddr_q < CAP18;
	assign clr_more = (maddr_q < mend_q) && maddr_ok;
	assign go       = (cmd.mop != ffaa_pkg::MOP_IDLE) && !mbusy_q && !mdone_q;
	assign rbyte    = ok_s1 ? rdata_s1 : 8'd0;

	always_comb begin
		case (cmd.asel)
			ffaa_pkg::ASEL_ZERO:   addr_mux = 18'd0;
			ffaa_pkg::ASEL_FOUR:   addr_mux = 18'd4;
			ffaa_pkg::ASEL_EIGHT:  addr_mux = 18'd8;
			ffaa_pkg::ASEL_HEAD:   addr_mux = {2'b0, head_q};
			ffaa_pkg::ASEL_P1:     addr_mux = p1_q;
			ffaa_pkg::ASEL_P1_4:   addr_mux = p1_q + 18'd4;
			ffaa_pkg::ASEL_P1_8:   addr_mux = p1_q + 18'd8;
			ffaa_pkg::ASEL_P2:     addr_mux = p2_q;
			ffaa_pkg::ASEL_P2_4:   addr_mux = p2_q + 18'd4;
			ffaa_pkg::ASEL_END:    addr_mux = end_q;
			ffaa_pkg::ASEL_END_4:  addr_mux = end_q + 18'd4;
			ffaa_pkg::ASEL_END_8:  addr_mux = end_q + 18'd8;
			ffaa_pkg::ASEL_TAIL:   addr_mux = {2'b0, tail_q};
			ffaa_pkg::ASEL_TAIL_8: addr_mux = {2'b0, tail_q} + 18'd8;
			ffaa_pkg::ASEL_TGT:    addr_mux = {2'b0, tgt_q};
			ffaa_pkg::ASEL_PRV:    addr_mux = prv_q;
			default:               addr_mux = 18'd0;
		endcase
	end

	always_comb begin
		case (cmd.dsel)
			ffaa_pkg::DSEL_ZERO:      data_mux = '0;
			ffaa_pkg::DSEL_HEAD_LIVE: data_mux = (live_q != '0) ? {8'd0, head_q} : '0;
			ffaa_pkg::DSEL_REQ:       data_mux = {7'd0, req_q};
			ffaa_pkg::DSEL_P1:        data_mux = {6'd0, p1_q};
			ffaa_pkg::DSEL_P2:        data_mux = {6'd0, p2_q};
			ffaa_pkg::DSEL_END:       data_mux = {6'd0, end_q};
			ffaa_pkg::DSEL_TAIL:      data_mux = {8'd0, tail_q};
			ffaa_pkg::DSEL_PRV:       data_mux = {6'd0, prv_q};
			default:                  data_mux = '0;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wd = 8'd0;
		if (mbusy_q) begin
			case (mop_q)
				ffaa_pkg::MOP_WRW: begin
					mem_we = maddr_ok;
					case (mcnt_q)
						2'd0:    mem_wd = mdat_q[7:0];
						2'd1:    mem_wd = mdat_q[15:8];
						2'd2:    mem_wd = mdat_q[23:16];
						default: mem_wd = 8'd0;
					endcase
				end
				ffaa_pkg::MOP_CLR: mem_we = clr_more;
				default: mem_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) arena_q[maddr_q[AW-1:0]] <= mem_wd;
		rdata_s1 <= arena_q[maddr_q[AW-1:0]];
		ok_s1    <= maddr_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
		end else begin
			mdone_q <= 1'b0;
			if (go) begin
				mbusy_q <= 1'b1;
			end else if (mbusy_q) begin
				case (mop_q)
					ffaa_pkg::MOP_CLR: begin
						if (!clr_more) begin
							mbusy_q <= 1'b0;
							mdone_q <= 1'b1;
						end
					end
					default: begin
						if (mcnt_q == 2'd3) begin
							mbusy_q <= 1'b0;
							mdone_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Access unit payload. A word read collects each byte in the cycle after its address.
	always_ff @(posedge clk) begin
		if (go) begin
			mop_q   <= cmd.mop;
			maddr_q <= addr_mux;
			mdat_q  <= data_mux;
			mcnt_q  <= 2'd0;
			mend_q  <= cmd.full_clr ? CAP18 : end_q;
		end else if (mbusy_q) begin
			mcnt_q  <= mcnt_q + 2'd1;
			maddr_q <= maddr_q + 18'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (mbusy_q && mop_q == ffaa_pkg::MOP_RDW) begin
			case (mcnt_q)
				2'd1:    w_q[7:0]   <= rbyte;
				2'd2:    w_q[15:8]  <= rbyte;
				2'd3:    w_q[23:16] <= rbyte;
				default: w_q[7:0]   <= w_q[7:0];
			endcase
		end
	end

	// List state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q  <= 17'(CAP);
			head_q <= '0;
			tail_q <= '0;
			live_q <= '0;
		end else if (arena_size_we) begin
			lim_q  <= (arena_size > 17'(CAP)) ? 17'(CAP) : arena_size;
			head_q <= '0;
			tail_q <= '0;
			live_q <= '0;
		end else begin
			case (cmd.act)
				ffaa_pkg::ACT_HEAD_ZERO: begin
					head_q <= '0;
					if (live_q == '0) tail_q <= '0;
					live_q <= live_q + 1'b1;
				end
				ffaa_pkg::ACT_GRANT_GAP:   live_q <= live_q + 1'b1;
				ffaa_pkg::ACT_GRANT_TAIL: begin
					tail_q <= end_q[15:0];
					live_q <= live_q + 1'b1;
				end
				ffaa_pkg::ACT_UNLINK_HEAD: head_q <= p2_q[15:0];
				ffaa_pkg::ACT_UNLINK_TAIL: tail_q <= prv_q[15:0];
				ffaa_pkg::ACT_FREE_DONE:   live_q <= live_q - 1'b1;
				default:                   live_q <= live_q;
			endcase
		end
	end

	// Working registers of the current request.
	always_ff @(posedge clk) begin
		case (cmd.act)
			ffaa_pkg::ACT_LOAD: begin
				op_q    <= op;
				req_q   <= request_size;
				tgt_q   <= target_offset;
				grant_q <= '0;
				byte_q  <= '0;
			end
			ffaa_pkg::ACT_HEAD_ZERO:  grant_q <= ffaa_pkg::HDR[15:0];
			ffaa_pkg::ACT_P1_HEAD: begin
				p1_q <= {2'b0, head_q};
				p2_q <= w_q[17:0];
				k_q  <= '0;
			end
			ffaa_pkg::ACT_S1_W:       s1_q  <= w_q[17:0];
			ffaa_pkg::ACT_END:        end_q <= p1_q + s1_q + ffaa_pkg::HDR;
			ffaa_pkg::ACT_GRANT_GAP:  grant_q <= end_q[15:0] + ffaa_pkg::HDR[15:0];
			ffaa_pkg::ACT_ADV: begin
				p1_q <= p2_q;
				p2_q <= w_q[17:0];
				k_q  <= k_q + 1'b1;
			end
			ffaa_pkg::ACT_TAIL_END:   end_q <= {2'b0, tail_q} + w_q[17:0] + ffaa_pkg::HDR;
			ffaa_pkg::ACT_GRANT_TAIL: grant_q <= end_q[15:0] + ffaa_pkg::HDR[15:0];
			ffaa_pkg::ACT_CUR_HEAD: begin
				p1_q <= {2'b0, head_q};
				k_q  <= '0;
			end
			ffaa_pkg::ACT_CUR_NEXT: begin
				p1_q <= w_q[17:0];
				k_q  <= k_q + 1'b1;
			end
			ffaa_pkg::ACT_NXT:        p2_q   <= w_q[17:0];
			ffaa_pkg::ACT_PRV:        prv_q  <= w_q[17:0];
			ffaa_pkg::ACT_RDB_DONE:   byte_q <= w_q[7:0];
			default:                  k_q    <= k_q;
		endcase
	end

	// Output register; a new result may be loaded in the cycle the old one leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.push) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			granted_offset <= grant_q;
			read_byte      <= byte_q;
		end
	end

	always_comb begin
		st.mem_done    = mdone_q;
		st.op          = op_q;
		st.need_gt_lim = need > lim18;
		st.front_ok    = (live_q == '0) || ({2'b0, head_q} >= need);
		st.w_zero      = (w_q == '0);
		st.k_lt_live   = k_q < live_q;
		st.gap_ok      = (p2_q >= end_q) && ((p2_q - end_q) >= need);
		st.tail_ok     = (end_q <= lim18) && ((lim18 - end_q) >= need)
			&& ((end_q + ffaa_pkg::HDR) <= 18'd65535);
		st.cur_match   = (p1_q + ffaa_pkg::HDR) == {2'b0, tgt_q};
		st.cur_is_head = p1_q == {2'b0, head_q};
		st.cur_is_tail = p1_q == {2'b0, tail_q};
		st.tgt_lt_lim  = {1'b0, tgt_q} < lim_q;
		st.out_busy    = out_valid && out_stall;
	end

endmodule

@@ hw/rtl/first_fit_arena_allocator.sv @@
// First-fit allocator over a byte arena held in one single-port memory.
// An allocate tries the front gap, then the gap after each block walked, then the tail;
// a free walks the list to the block, unlinks it and clears it. One request is in
// flight at a time. After reset and after each arena_size write, a clearing pass
// zeroes the arena; requests wait until it ends.
module first_fit_arena_allocator #(
	parameter int ARENA_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        arena_size_we,
	input  logic [16:0] arena_size,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [16:0] request_size,
	input  logic [15:0] target_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] granted_offset,
	output logic [7:0]  read_byte
);

	ffaa_pkg::ctl_cmd_t  cmd;
	ffaa_pkg::ctl_stat_t st;

	ffaa_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.arena_size_we (arena_size_we),
		.st            (st),
		.cmd           (cmd),
		.in_stall      (in_stall)
	);

	ffaa_datapath #(
		.ARENA_BYTES (ARENA_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.arena_size_we  (arena_size_we),
		.arena_size     (arena_size),
		.op             (op),
		.request_size   (request_size),
		.target_offset  (target_offset),
		.out_stall      (out_stall),
		.cmd            (cmd),
		.st             (st),
		.out_valid      (out_valid),
		.granted_offset (granted_offset),
		.read_byte      (read_byte)
	);

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for first_fit_arena_allocator.
// Drives allocate, free and read requests and checks every result against a local allocator model
// or, for directed requests, a given expected value. Depends on ffaa_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int unsigned ARENA_CAP = 65536;
	localparam int unsigned HDR_B = 12;
	localparam int unsigned CYCLE_LIMIT = 40000000;
	localparam int ITEMS_PER_PHASE = 260;

	typedef struct {
		logic [1:0]  op;
		logic [16:0] size;
		logic [15:0] tgt;
		bit          typed;
		logic [15:0] grant;
		logic [7:0]  rbyte;
	} alloc_request_t;

	typedef struct {
		logic [15:0] grant;
		logic [7:0]  rbyte;
	} alloc_answer_t;

	logic        clk;
	logic        arst_n;
	logic        arena_size_we;
	logic [16:0] arena_size;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [16:0] request_size;
	logic [15:0] target_offset;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] granted_offset;
	logic [7:0]  read_byte;

	// Model state of the allocator.
	logic [7:0]  mdl_mem [ARENA_CAP];
	int unsigned mdl_head, mdl_tail, mdl_live, mdl_size;
	int unsigned live_payloads [$];

	alloc_answer_t answers_due [$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int idle_mode = 0;
	int hold_off = 0;

	first_fit_arena_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.arena_size_we(arena_size_we), .arena_size(arena_size),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .request_size(request_size), .target_offset(target_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.granted_offset(granted_offset), .read_byte(read_byte)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int unsigned mem_rd(int unsigned a);
		return (a < ARENA_CAP) ? int'(mdl_mem[a]) : 0;
	endfunction

	function automatic void mem_wr(int unsigned a, int unsigned v);
		if (a < ARENA_CAP)
			mdl_mem[a] = v[7:0];
	endfunction

	function automatic int unsigned word_rd(int unsigned a);
		return mem_rd(a) | (mem_rd(a + 1) << 8) | (mem_rd(a + 2) << 16);
	endfunction

	function automatic void word_wr(int unsigned a, int unsigned v);
		mem_wr(a, v);
		mem_wr(a + 1, v >> 8);
		mem_wr(a + 2, v >> 16);
		mem_wr(a + 3, 0);
	endfunction

	function automatic int unsigned arena_limit();
		return (mdl_size > ARENA_CAP) ? ARENA_CAP : mdl_size;
	endfunction

	function automatic void arena_clear();
		foreach (mdl_mem[i])
			mdl_mem[i] = 8'd0;
		mdl_head = 0;
		mdl_tail = 0;
		mdl_live = 0;
		live_payloads.delete();
	endfunction

	function automatic int unsigned place_block(int unsigned size);
		int unsigned need, lim, p1, p2, s1, fin;
		need = size + HDR_B;
		lim = arena_limit();
		if (need > lim)
			return 0;
		if (mdl_live == 0 || mdl_head >= need) begin
			word_wr(0, mdl_live != 0 ? mdl_head : 0);
			word_wr(4, 0);
			word_wr(8, size);
			mdl_head = 0;
			if (mdl_live == 0)
				mdl_tail = 0;
			mdl_live++;
			return HDR_B;
		end
		if (word_rd(mdl_head) != 0) begin
			p1 = mdl_head;
			s1 = word_rd(p1 + 8);
			p2 = word_rd(p1);
			for (int unsigned k = 0; k < mdl_live; k++) begin
				fin = p1 + s1 + HDR_B;
				if (p2 >= fin && p2 - fin >= need) begin
					word_wr(fin, p2);
					word_wr(fin + 4, p1);
					word_wr(fin + 8, size);
					word_wr(p1, fin);
					word_wr(p2 + 4, fin);
					mdl_live++;
					return fin + HDR_B;
				end
				if (word_rd(p2) == 0)
					break;
				p1 = p2;
				s1 = word_rd(p2 + 8);
				p2 = word_rd(p2);
			end
		end
		fin = mdl_tail + word_rd(mdl_tail + 8) + HDR_B;
		if (fin <= lim && lim - fin >= need && fin + HDR_B <= 65535) begin
			word_wr(fin, 0);
			word_wr(fin + 4, mdl_tail);
			word_wr(fin + 8, size);
			word_wr(mdl_tail, fin);
			mdl_tail = fin;
			mdl_live++;
			return fin + HDR_B;
		end
		return 0;
	endfunction

	function automatic void release_block(int unsigned target);
		int unsigned cur, nxt, prv, size;
		bit found;
		cur = mdl_head;
		found = 0;
		for (int unsigned k = 0; k < mdl_live; k++) begin
			if (cur + HDR_B == target) begin
				found = 1;
				break;
			end
			cur = word_rd(cur);
		end
		if (!found)
			return;
		nxt = word_rd(cur);
		prv = word_rd(cur + 4);
		size = word_rd(cur + 8);
		if (cur != mdl_head)
			word_wr(prv, nxt);
		else
			mdl_head = nxt;
		if (cur != mdl_tail)
			word_wr(nxt + 4, prv);
		else
			mdl_tail = prv;
		for (int unsigned a = cur; a < cur + size + HDR_B && a < ARENA_CAP; a++)
			mdl_mem[a] = 8'd0;
		mdl_live--;
		foreach (live_payloads[i])
			if (live_payloads[i] == target) begin
				live_payloads.delete(i);
				break;
			end
	endfunction

	function automatic alloc_answer_t serve_request(logic [1:0] rop, logic [16:0] size,
			logic [15:0] tgt);
		alloc_answer_t ans;
		int unsigned g;
		ans.grant = '0;
		ans.rbyte = '0;
		case (rop)
			ffaa_pkg::OP_ALLOC: begin
				g = place_block(size);
				ans.grant = g[15:0];
				if (g != 0)
					live_payloads.push_back(g);
			end
			ffaa_pkg::OP_FREE: release_block(tgt);
			ffaa_pkg::OP_READ: begin
				if (tgt < arena_limit())
					ans.rbyte = mdl_mem[tgt];
			end
			default: ;
		endcase
		return ans;
	endfunction

	// Offers one request from the falling edge and holds it until accepted.
	task automatic offer_request(alloc_request_t r);
		alloc_answer_t ans;
		in_valid = 1'b1;
		op = r.op;
		request_size = r.size;
		target_offset = r.tgt;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		ans = serve_request(r.op, r.size, r.tgt);
		if (r.typed) begin
			ans.grant = r.grant;
			ans.rbyte = r.rbyte;
		end
		answers_due.push_back(ans);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		int p;
		p = (idle_mode == 1) ? 74 : (idle_mode == 3) ? 21 : 0;
		while ($urandom_range(99) < p) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic drain_answers();
		in_valid = 1'b0;
		while (answers_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_arena_size(logic [16:0] v);
		drain_answers();
		repeat (20) @(negedge clk);
		arena_size_we = 1'b1;
		arena_size = v;
		@(negedge clk);
		arena_size_we = 1'b0;
		mdl_size = v;
		arena_clear();
	endtask

	function automatic alloc_request_t random_request();
		alloc_request_t r;
		int pick;
		r.typed = 0;
		r.grant = '0;
		r.rbyte = '0;
		r.size = '0;
		r.tgt = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 42) begin
			r.op = ffaa_pkg::OP_ALLOC;
			pick = $urandom_range(99);
			if (pick < 90)
				r.size = 17'($urandom_range(40));
			else if (pick < 98)
				r.size = 17'($urandom_range(2000));
			else
				r.size = 17'($urandom);
		end else if (pick < 72) begin
			r.op = ffaa_pkg::OP_FREE;
			if (live_payloads.size() != 0)
				r.tgt = 16'(live_payloads[$urandom_range(live_payloads.size() - 1)]);
		end else if (pick < 77) begin
			r.op = ffaa_pkg::OP_FREE;
		end else if (pick < 95) begin
			r.op = ffaa_pkg::OP_READ;
			// Half the reads land where blocks usually live.
			if ($urandom_range(1) == 0)
				r.tgt = 16'($urandom_range(600));
		end else begin
			r.op = OP_NOP;
			r.size = 17'($urandom);
		end
		return r;
	endfunction

	always @(negedge clk) begin
		int p;
		p = (idle_mode == 2) ? 74 : (idle_mode == 3) ? 21 : 0;
		if (hold_off > 0) begin
			out_stall <= 1'b1;
			hold_off <= hold_off - 1;
		end else begin
			out_stall <= ($urandom_range(99) < p);
		end
	end

	always @(posedge clk) begin
		alloc_answer_t ans;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: granted %0d byte %0h", granted_offset,
						read_byte);
			end else begin
				ans = answers_due.pop_front();
				if (ans.grant !== granted_offset || ans.rbyte !== read_byte) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: granted exp %0d got %0d, byte exp %0h got %0h",
							ans.grant, granted_offset, ans.rbyte, read_byte);
				end
			end
		end
	end

	initial begin
		alloc_request_t directed [$];
		logic [16:0] settings [$];
		int n;
		arst_n = 1'b0;
		arena_size_we = 1'b0;
		arena_size = 17'd65536;
		in_valid = 1'b0;
		op = OP_NOP;
		request_size = '0;
		target_offset = '0;
		out_stall = 1'b0;
		mdl_size = 65536;
		arena_clear();

		directed.push_back('{ffaa_pkg::OP_READ, 17'd0, 16'd0, 1, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_ALLOC, 17'd131071, 16'd0, 1, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_ALLOC, 17'd65536, 16'd0, 1, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_ALLOC, 17'd65512, 16'd0, 1, 16'd12, 8'd0});
		// A zero-size block right at the end would put its payload past 16 bits.
		directed.push_back('{ffaa_pkg::OP_ALLOC, 17'd0, 16'd0, 1, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_READ, 17'd0, 16'd8, 0, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_FREE, 17'd0, 16'd12, 0, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_READ, 17'd0, 16'd9, 1, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_ALLOC, 17'd0, 16'd0, 1, 16'd12, 8'd0});
		directed.push_back('{ffaa_pkg::OP_ALLOC, 17'd10, 16'd0, 0, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_ALLOC, 17'd5, 16'd0, 0, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_FREE, 17'd0, 16'd24, 0, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_ALLOC, 17'd3, 16'd0, 0, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_FREE, 17'd0, 16'd999, 0, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_FREE, 17'd0, 16'd12, 0, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_ALLOC, 17'd0, 16'd0, 0, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_READ, 17'd0, 16'd65535, 0, 16'd0, 8'd0});
		directed.push_back('{OP_NOP, 17'd131071, 16'd65535, 1, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_FREE, 17'd0, 16'd65535, 0, 16'd0, 8'd0});
		directed.push_back('{ffaa_pkg::OP_READ, 17'd0, 16'd30, 0, 16'd0, 8'd0});

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			offer_request(directed[i]);
		drain_answers();

		settings = '{17'd65536, 17'd12, 17'd300, 17'd131071, 17'd2000, 17'd65536};
		n = 0;
		foreach (settings[s]) begin
			if (s != 0)
				write_arena_size(settings[s]);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				idle_mode = (n / 50) % 4;
				if (s == 2 && i == 100) begin
					idle_mode = 0;
					hold_off = 3000;
				end
				if (s == 2 && i == 160)
					drain_answers();
				sender_gap();
				offer_request(random_request());
				n++;
			end
		end
		drain_answers();
		repeat (300) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
